>>> sv/twms_pkg.sv
// ----------------------------------------------------------------------------
// Three-window maximum sum: shared types and constants
// Word layouts for the sample and result channels, field widths and the
// status codes of a result word.
// ----------------------------------------------------------------------------
package twms_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int START_W   = 10;
  localparam int SUM_OUT_W = 26;
  localparam int WIN_W     = 9;
  localparam int NUM_WIN   = 3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } twms_in_t;

  typedef struct packed {
    logic [START_W-1:0]   first_start;
    logic [START_W-1:0]   second_start;
    logic [START_W-1:0]   third_start;
    logic [SUM_OUT_W-1:0] best_sum;
    logic                 status;
  } twms_out_t;

endpackage

>>> sv/three_window_max_sum.sv
// Samples load one word per cycle while the block is idle. After the last
// word the search checks the length, then runs a backward table pass and a
// forward backtrack of at most n-k+1 steps; a too-short sequence skips both.
// The rate is set by the single shared adder-comparator and the one read port
// per table memory. Reset clears the sequencer, counters and window length
// (to 1); the prefix and table memories are not cleared.
// ----------------------------------------------------------------------------
// Three-window maximum sum
// Loads samples as prefix sums, then runs a backward table pass and a forward
// backtrack on one shared adder-comparator to pick three windows.
// ----------------------------------------------------------------------------
module three_window_max_sum import twms_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  twms_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output twms_out_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WIN_W-1:0]  cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int AW    = CNT_W;
  localparam int POS_W = $clog2(MAX_LEN + 2);
  localparam int EXT_W = ((POS_W > 11) ? POS_W : 11) + 1;
  localparam int SUM_W = SAMPLE_W + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_PRD, S_PWIN, S_PJ1, S_PJ2, S_PJ3,
    S_BRD, S_BWIN, S_BCMP, S_OUT
  } state_e;

  state_e             state_q;
  logic [WIN_W-1:0]   win_len_q;
  logic [CNT_W-1:0]   count_q;
  logic [SUM_W-1:0]   sum_q;
  logic [POS_W-1:0]   n_q, top_q, pos_q;
  logic [1:0]         j_q;
  logic [SUM_W-1:0]   win_q, sk1_q, sk2_q, sk3_q, best_q;
  logic [START_W-1:0] st1_q, st2_q, st3_q;
  logic               status_q;
  logic               out_valid_q;
  twms_out_t          out_q;

  logic [SUM_W-1:0] pf_mem [MAX_LEN+1];
  logic [SUM_W-1:0] b1_mem [MAX_LEN+1];
  logic [SUM_W-1:0] b2_mem [MAX_LEN+1];
  logic [SUM_W-1:0] b3_mem [MAX_LEN+1];
  logic [SUM_W-1:0] pf_hi_q, pf_lo_q, b1_rd_q, b2_rd_q, b3_rd_q;
  logic             lo_zero_q, far_zero_q, near_zero_q;

  logic             in_acc, full, rd_en, bt;
  logic [POS_W-1:0] pos_rd;
  logic [EXT_W-1:0] k_x, pos_rd_x, far_x, hi_x, lo_x, near_x, top_x, n_x;
  logic [AW-1:0]    b1_addr, b2_addr, b3_addr;
  logic [SUM_W-1:0] au_a, au_b, au_c, au_res, pass_best, base_bt, skip_bt;
  logic             au_ci, au_ge;
  logic [EXT_W-1:0] pos_bt_x;
  logic [1:0]       j_bt;
  logic             bt_cont;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full        = (count_q == CNT_W'(MAX_LEN));

  assign pos_rd   = (state_q == S_PJ3) ? pos_q - POS_W'(1) : pos_q;
  assign k_x      = EXT_W'(win_len_q);
  assign pos_rd_x = EXT_W'(pos_rd);
  assign far_x    = pos_rd_x + k_x;
  assign hi_x     = far_x - EXT_W'(1);
  assign lo_x     = pos_rd_x - EXT_W'(1);
  assign near_x   = EXT_W'(pos_q) + EXT_W'(1);
  assign top_x    = EXT_W'(top_q);
  assign n_x      = EXT_W'(n_q);
  assign rd_en    = (state_q == S_PRD) || (state_q == S_PJ3) || (state_q == S_BRD);
  assign bt       = (state_q == S_BRD);
  assign b1_addr  = (bt && j_q == 2'd1) ? near_x[AW-1:0] : far_x[AW-1:0];
  assign b2_addr  = (bt && j_q == 2'd2) ? near_x[AW-1:0] : far_x[AW-1:0];
  assign b3_addr  = near_x[AW-1:0];

  always_comb begin
    unique case (j_q)
      2'd2:    base_bt = far_zero_q ? '0 : b1_rd_q;
      2'd3:    base_bt = far_zero_q ? '0 : b2_rd_q;
      default: base_bt = '0;
    endcase
    unique case (j_q)
      2'd1:    skip_bt = near_zero_q ? '0 : b1_rd_q;
      2'd2:    skip_bt = near_zero_q ? '0 : b2_rd_q;
      default: skip_bt = near_zero_q ? '0 : b3_rd_q;
    endcase
  end

  // The shared adder-comparator: res = a + b + ci, ge = (res >= c).
  always_comb begin
    au_a  = sum_q;
    au_b  = SUM_W'(in_data_i.sample);
    au_ci = 1'b0;
    au_c  = '0;
    unique case (state_q)
      S_PWIN, S_BWIN: begin
        au_a  = pf_hi_q;
        au_b  = ~(lo_zero_q ? '0 : pf_lo_q);
        au_ci = 1'b1;
      end
      S_PJ1: begin
        au_a = win_q;
        au_b = '0;
        au_c = sk1_q;
      end
      S_PJ2: begin
        au_a = win_q;
        au_b = far_zero_q ? '0 : b1_rd_q;
        au_c = sk2_q;
      end
      S_PJ3: begin
        au_a = win_q;
        au_b = far_zero_q ? '0 : b2_rd_q;
        au_c = sk3_q;
      end
      S_BCMP: begin
        au_a = win_q;
        au_b = base_bt;
        au_c = skip_bt;
      end
      default: begin
        au_a = sum_q;
      end
    endcase
    au_res    = au_a + au_b + SUM_W'(au_ci);
    au_ge     = (au_res >= au_c);
    pass_best = au_ge ? au_res : au_c;
  end

  assign pos_bt_x = au_ge ? EXT_W'(pos_q) + k_x : EXT_W'(pos_q) + EXT_W'(1);
  assign j_bt     = au_ge ? j_q - 2'd1 : j_q;
  assign bt_cont  = (j_bt != 2'd0) && (pos_bt_x <= top_x);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc && !full) begin
      pf_mem[AW'(count_q + CNT_W'(1))] <= au_res;
    end
    if (rd_en) begin
      pf_hi_q <= pf_mem[hi_x[AW-1:0]];
      pf_lo_q <= pf_mem[lo_x[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PJ1) begin
      b1_mem[pos_q[AW-1:0]] <= pass_best;
    end
    if (state_q == S_PJ2) begin
      b2_mem[pos_q[AW-1:0]] <= pass_best;
    end
    if (state_q == S_PJ3) begin
      b3_mem[pos_q[AW-1:0]] <= pass_best;
    end
    if (rd_en) begin
      b1_rd_q     <= b1_mem[b1_addr];
      b2_rd_q     <= b2_mem[b2_addr];
      b3_rd_q     <= b3_mem[b3_addr];
      lo_zero_q   <= (pos_rd == POS_W'(1));
      far_zero_q  <= (far_x > top_x);
      near_zero_q <= (near_x > top_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_len_q   <= WIN_W'(1);
      count_q     <= '0;
      sum_q       <= '0;
      n_q         <= '0;
      top_q       <= '0;
      pos_q       <= '0;
      j_q         <= '0;
      win_q       <= '0;
      sk1_q       <= '0;
      sk2_q       <= '0;
      sk3_q       <= '0;
      best_q      <= '0;
      st1_q       <= '0;
      st2_q       <= '0;
      st3_q       <= '0;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_len_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!full) begin
              count_q <= count_q + CNT_W'(1);
              sum_q   <= au_res;
            end
            if (in_data_i.last) begin
              n_q     <= POS_W'(count_q) + (full ? POS_W'(0) : POS_W'(1));
              state_q <= S_CHK;
            end
          end
        end
        S_CHK: begin
          count_q <= '0;
          sum_q   <= '0;
          st1_q   <= '0;
          st2_q   <= '0;
          st3_q   <= '0;
          sk1_q   <= '0;
          sk2_q   <= '0;
          sk3_q   <= '0;
          best_q  <= '0;
          if (win_len_q == '0 || n_x < EXT_W'(NUM_WIN) * k_x) begin
            status_q <= STATUS_SHORT;
            state_q  <= S_OUT;
          end else begin
            status_q <= STATUS_OK;
            top_q    <= POS_W'(n_x - k_x + EXT_W'(1));
            pos_q    <= POS_W'(n_x - k_x + EXT_W'(1));
            state_q  <= S_PRD;
          end
        end
        S_PRD: begin
          state_q <= S_PWIN;
        end
        S_PWIN: begin
          win_q   <= au_res;
          state_q <= S_PJ1;
        end
        S_PJ1: begin
          sk1_q   <= pass_best;
          state_q <= S_PJ2;
        end
        S_PJ2: begin
          sk2_q   <= pass_best;
          state_q <= S_PJ3;
        end
        S_PJ3: begin
          sk3_q <= pass_best;
          if (pos_q == POS_W'(1)) begin
            best_q  <= pass_best;
            j_q     <= 2'd3;
            state_q <= S_BRD;
          end else begin
            pos_q   <= pos_rd;
            state_q <= S_PWIN;
          end
        end
        S_BRD: begin
          state_q <= S_BWIN;
        end
        S_BWIN: begin
          win_q   <= au_res;
          state_q <= S_BCMP;
        end
        S_BCMP: begin
          if (au_ge) begin
            unique case (j_q)
              2'd3:    st1_q <= START_W'(pos_q - POS_W'(1));
              2'd2:    st2_q <= START_W'(pos_q - POS_W'(1));
              default: st3_q <= START_W'(pos_q - POS_W'(1));
            endcase
          end
          pos_q   <= POS_W'(pos_bt_x);
          j_q     <= j_bt;
          state_q <= bt_cont ? S_BRD : S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.first_start  <= st1_q;
            out_q.second_start <= st2_q;
            out_q.third_start  <= st3_q;
            out_q.best_sum     <= SUM_OUT_W'(best_q);
            out_q.status       <= status_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/twms_checker.sv
// ----------------------------------------------------------------------------
// Three-window maximum sum: port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module twms_checker import twms_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input twms_in_t         in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input twms_out_t        out_data_o
);

  // A stalled result word stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // Once the final sample is taken, the block is busy with the search.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last |=> in_stall_o)
    else $error("sample taken straight after the final sample");

  // A new result only appears at the end of a search.
  a_result_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without a search");

  // A short sequence gives an all-zero result.
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_SHORT |->
      out_data_o.first_start == '0 && out_data_o.second_start == '0 &&
      out_data_o.third_start == '0 && out_data_o.best_sum == '0)
    else $error("short sequence result not cleared");

  // Chosen windows start in increasing order.
  a_start_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_OK |->
      out_data_o.first_start < out_data_o.second_start &&
      out_data_o.second_start < out_data_o.third_start)
    else $error("window starts out of order");

endmodule

bind three_window_max_sum twms_checker u_twms_checker (.*);
